// File: sv/comment_strip_entry_point_scanner_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef COMMENT_STRIP_ENTRY_POINT_SCANNER_MACROS_SVH
`define COMMENT_STRIP_ENTRY_POINT_SCANNER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define CSSC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define CSSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/cssc_pkg.sv
// Package: types, name tables and the per-byte scan step of the scanner.
`default_nettype none
package cssc_pkg;

    localparam int unsigned NAME_COUNT = 7;
    localparam int unsigned NAME_SLOTS = 16;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_LINE       = 2'd1,
        MODE_BLOCK      = 2'd2,
        MODE_BLOCK_STAR = 2'd3
    } t_mode;

    typedef struct packed {
        logic                  prev_ident;
        logic [3:0]            tok_len;
        logic [NAME_COUNT-1:0] prefix;
        logic [NAME_COUNT-1:0] await_paren;
        logic [NAME_COUNT-1:0] found;
    } t_scan;

    localparam t_scan SCAN_RESET = '{
        prev_ident:  1'b0,
        tok_len:     4'd0,
        prefix:      {NAME_COUNT{1'b1}},
        await_paren: {NAME_COUNT{1'b0}},
        found:       {NAME_COUNT{1'b0}}
    };

    // Entry names, NUL padded to 16 so a token position always indexes in range.
    localparam logic [7:0] NAME_TEXT [NAME_COUNT][NAME_SLOTS] = '{
        '{"V","S","M","a","i","n",CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,
          CH_NUL,CH_NUL,CH_NUL},
        '{"P","S","M","a","i","n",CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,
          CH_NUL,CH_NUL,CH_NUL},
        '{"V","S","S","k","i","n","n","e","d","M","a","i","n",CH_NUL,CH_NUL,CH_NUL},
        '{"P","S","S","k","i","n","n","e","d","M","a","i","n",CH_NUL,CH_NUL,CH_NUL},
        '{"H","S","M","a","i","n",CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,
          CH_NUL,CH_NUL,CH_NUL},
        '{"D","S","M","a","i","n",CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,
          CH_NUL,CH_NUL,CH_NUL},
        '{"C","S","M","a","i","n",CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,CH_NUL,
          CH_NUL,CH_NUL,CH_NUL}
    };

    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
        4'd6, 4'd6, 4'd13, 4'd13, 4'd6, 4'd6, 4'd6
    };

    function automatic logic is_ident(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || (c == "_");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // One byte of the blanked stream through the token matcher.
    function automatic t_scan scan_step(t_scan s, logic [7:0] c);
        t_scan r;
        r = s;
        if (is_ident(c)) begin
            if (!s.prev_ident) begin
                r.tok_len = 4'd0;
                r.prefix  = {NAME_COUNT{1'b1}};
            end
            // padding is NUL, never an identifier byte, so overlong tokens drop out
            for (int i = 0; i < NAME_COUNT; i++) begin
                if (NAME_TEXT[i][r.tok_len] != c) begin
                    r.prefix[i] = 1'b0;
                end
            end
            if (r.tok_len != 4'hF) begin
                r.tok_len = r.tok_len + 4'd1;
            end
            r.await_paren = '0;
            r.prev_ident  = 1'b1;
        end else begin
            if (s.prev_ident) begin
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (s.prefix[i] && (s.tok_len == NAME_LEN[i])) begin
                        r.await_paren[i] = 1'b1;
                    end
                end
            end
            if (c == CH_LPAREN) begin
                r.found       = r.found | r.await_paren;
                r.await_paren = '0;
            end else if (!is_space(c)) begin
                r.await_paren = '0;
            end
            r.prev_ident = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: sv/cssc_ifs.sv
// Valid/ready channel interfaces for the source bytes and the found-flag report.
`default_nettype none
interface cssc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

interface cssc_out_if;
    logic valid;
    logic ready;
    logic has_vertex;
    logic has_pixel;
    logic has_skinned_vertex;
    logic has_skinned_pixel;
    logic has_hull;
    logic has_domain;
    logic has_compute;

    modport source (
        output valid, output has_vertex, output has_pixel, output has_skinned_vertex,
        output has_skinned_pixel, output has_hull, output has_domain,
        output has_compute, input ready
    );
    modport sink (
        input valid, input has_vertex, input has_pixel, input has_skinned_vertex,
        input has_skinned_pixel, input has_hull, input has_domain,
        input has_compute, output ready
    );
endinterface
`default_nettype wire

// File: sv/comment_strip_entry_point_scanner.sv
// Comment-stripping entry-point scanner: top level.
//
// i_in carries source text, one byte per request (text_byte, is_last).
// Comments are blanked on the fly (line comments up to the newline, block
// comments keep their newlines, "/*/" is a whole comment) and the blanked
// stream is matched against seven entry names followed by optional
// whitespace and '('. The request whose is_last is set closes the text:
// a held trailing slash is scanned, one report request with the seven
// found flags goes out on o_out, and the scan state returns to reset so
// the next byte starts a new text. Other bytes produce no report.
// A byte passes the input register, then the state and report registers,
// the latter driving o_out. Throughput is one byte per cycle unless a last
// byte waits on a stalled report, set by the single byte register feeding
// one pass of the stripper plus up to three chained scan steps into both.
// When o_out stalls, the held report stays put; following non-last bytes
// keep flowing, and only a second last byte waits in the input register
// until the report is taken, which then backpressures i_in.
// Reset (i_rst_n low, synchronous) empties both registers and sets the
// stripper to normal text with all match state cleared.
`default_nettype none
module comment_strip_entry_point_scanner
    import cssc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    cssc_in_if.sink     i_in,
    cssc_out_if.source  o_out
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // stripper and scanner state
    t_mode r_mode, n_mode;
    logic  r_slash, n_slash;
    t_scan r_scan, n_scan;

    // report register
    logic                  r_out_valid;
    logic [NAME_COUNT-1:0] r_out_flags;

    logic       proc;
    logic       emit1, emit2, emit3;
    logic [7:0] ch1, ch2;
    t_scan      scan_a, scan_b;

    // a non-last byte never waits; a last byte needs the report slot free
    assign proc       = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.text_byte;
            r_in_last <= i_in.is_last;
        end
    end

    // Stripper: each source byte yields up to two bytes for the scanner.
    always_comb begin
        n_mode  = r_mode;
        n_slash = r_slash;
        emit1   = 1'b0;
        emit2   = 1'b0;
        ch1     = CH_SPACE;
        ch2     = CH_SPACE;
        unique case (r_mode)
            MODE_NORMAL: begin
                if (r_slash) begin
                    n_slash = 1'b0;
                    emit1   = 1'b1;
                    emit2   = 1'b1;
                    if (r_in_byte == CH_SLASH) begin
                        n_mode = MODE_LINE;
                    end else if (r_in_byte == CH_STAR) begin
                        n_mode = MODE_BLOCK_STAR;  // opener star may close it
                    end else begin
                        ch1 = CH_SLASH;
                        ch2 = r_in_byte;
                    end
                end else if (r_in_byte == CH_SLASH) begin
                    n_slash = 1'b1;
                end else begin
                    emit1 = 1'b1;
                    ch1   = r_in_byte;
                end
            end
            MODE_LINE: begin
                emit1 = 1'b1;
                if (r_in_byte == CH_NL) begin
                    ch1    = CH_NL;
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_BLOCK: begin
                emit1 = 1'b1;
                if (r_in_byte == CH_NL) begin
                    ch1 = CH_NL;
                end
                if (r_in_byte == CH_STAR) begin
                    n_mode = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                emit1 = 1'b1;
                if (r_in_byte == CH_SLASH) begin
                    n_mode = MODE_NORMAL;
                end else if (r_in_byte != CH_STAR) begin
                    if (r_in_byte == CH_NL) begin
                        ch1 = CH_NL;
                    end
                    n_mode = MODE_BLOCK;
                end
            end
        endcase

        // flush of a slash still held at end of text
        emit3  = r_in_last && n_slash;
        scan_a = emit1 ? scan_step(r_scan, ch1) : r_scan;
        scan_b = emit2 ? scan_step(scan_a, ch2) : scan_a;
        n_scan = emit3 ? scan_step(scan_b, CH_SLASH) : scan_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_slash <= 1'b0;
            r_scan  <= SCAN_RESET;
        end else if (proc) begin
            if (r_in_last) begin
                r_mode  <= MODE_NORMAL;
                r_slash <= 1'b0;
                r_scan  <= SCAN_RESET;
            end else begin
                r_mode  <= n_mode;
                r_slash <= n_slash;
                r_scan  <= n_scan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (proc && r_in_last) begin
            r_out_flags <= n_scan.found;
        end
    end

    assign o_out.valid              = r_out_valid;
    assign o_out.has_vertex         = r_out_flags[0];
    assign o_out.has_pixel          = r_out_flags[1];
    assign o_out.has_skinned_vertex = r_out_flags[2];
    assign o_out.has_skinned_pixel  = r_out_flags[3];
    assign o_out.has_hull           = r_out_flags[4];
    assign o_out.has_domain         = r_out_flags[5];
    assign o_out.has_compute        = r_out_flags[6];

`include "comment_strip_entry_point_scanner_macros.svh"

    `CSSC_ASSERT_NEXT(a_end_clears_state, proc && r_in_last,
        r_mode == MODE_NORMAL && !r_slash && r_scan.found == '0 && !r_scan.prev_ident)
    `CSSC_ASSERT_NOW(a_plain_byte_no_stall, r_in_valid && !r_in_last, proc)
    `CSSC_ASSERT_NEXT(a_report_held, r_out_valid && !o_out.ready, r_out_valid)
    `CSSC_ASSERT_NEXT(a_report_only_at_end, !r_out_valid && !(proc && r_in_last),
        !r_out_valid)

endmodule
`default_nettype wire

// File: bench/tb_comment_strip_entry_point_scanner.sv
// Testbench for the comment-stripping entry-point scanner: directed texts, then random texts.
`timescale 1ns / 100ps
module tb_comment_strip_entry_point_scanner;
    import cssc_pkg::*;

    // Random part length in source bytes.
    localparam int unsigned RANDOM_BYTES = 1700;

    // Found-flag words, bit i = entry name i (vertex is bit 0, compute is bit 6).
    localparam logic [NAME_COUNT-1:0] FOUND_NONE    = '0;
    localparam logic [NAME_COUNT-1:0] FOUND_COMPUTE = 7'b100_0000;

    // Same order as the report fields.
    string entry_name [NAME_COUNT] = '{
        "VSMain", "PSMain", "VSSkinnedMain", "PSSkinnedMain", "HSMain", "DSMain", "CSMain"
    };
    string field_name [NAME_COUNT] = '{
        "has_vertex", "has_pixel", "has_skinned_vertex", "has_skinned_pixel",
        "has_hull", "has_domain", "has_compute"
    };
    string word_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    string punct_pool = ");{/*,=";
    localparam logic [7:0] BLANK_BYTES [6] = '{CH_SPACE, 8'h09, CH_NL, 8'h0B, 8'h0C, 8'h0D};

    logic i_clk;
    logic i_rst_n;

    cssc_in_if  in_if ();
    cssc_out_if out_if ();

    comment_strip_entry_point_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Scanner model: stripper mode plus token matcher state.
    // ------------------------------------------------------------------
    typedef struct {
        t_mode                 mode;
        logic                  slash_held;    // '/' seen in normal text, not yet resolved
        logic                  in_word;       // last blanked byte was an identifier byte
        logic [3:0]            word_len;      // saturates at 15
        logic [NAME_COUNT-1:0] still_match;   // names the current token still matches
        logic [NAME_COUNT-1:0] want_paren;    // names waiting on '(' past whitespace
        logic [NAME_COUNT-1:0] found;
    } t_scanner_state;

    t_scanner_state scanner;

    logic [NAME_COUNT-1:0] pending_reports [$];   // found flags still owed by the DUT
    logic [7:0]            text_bytes [$];        // random text under construction

    typedef struct {
        logic [7:0]            ch;
        logic                  last;
        logic                  known;             // flags typed in, not taken from the model
        logic [NAME_COUNT-1:0] flags;
    } t_text_row;

    t_text_row directed_rows [$];

    int  error_count;
    int  accepted_bytes;
    bit  no_idle;

    function automatic void clear_scanner();
        scanner.mode        = MODE_NORMAL;
        scanner.slash_held  = 1'b0;
        scanner.in_word     = 1'b0;
        scanner.word_len    = 4'd0;
        scanner.still_match = '1;
        scanner.want_paren  = '0;
        scanner.found       = '0;
    endfunction

    function automatic logic is_word_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_";
    endfunction

    // Token matcher, fed with the comment-blanked stream.
    function automatic void match_blanked_byte(logic [7:0] c);
        if (is_word_byte(c)) begin
            if (!scanner.in_word) begin
                scanner.word_len    = 4'd0;
                scanner.still_match = '1;
            end
            for (int i = 0; i < NAME_COUNT; i++) begin
                if (scanner.still_match[i]) begin
                    if (scanner.word_len >= entry_name[i].len())
                        scanner.still_match[i] = 1'b0;
                    else if (entry_name[i][scanner.word_len] != c)
                        scanner.still_match[i] = 1'b0;
                end
            end
            if (scanner.word_len != 4'd15)
                scanner.word_len++;
            scanner.want_paren = '0;
            scanner.in_word    = 1'b1;
        end else begin
            // token just ended: full-length survivors start waiting on '('
            if (scanner.in_word) begin
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (scanner.still_match[i] && scanner.word_len == entry_name[i].len())
                        scanner.want_paren[i] = 1'b1;
                end
            end
            if (c == CH_LPAREN) begin
                scanner.found      = scanner.found | scanner.want_paren;
                scanner.want_paren = '0;
            end else if (!(c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))) begin
                scanner.want_paren = '0;
            end
            scanner.in_word = 1'b0;
        end
    endfunction

    // Comment stripper: comment bytes turn into blanks, block newlines survive.
    function automatic void strip_source_byte(logic [7:0] c);
        case (scanner.mode)
            MODE_NORMAL: begin
                if (scanner.slash_held) begin
                    scanner.slash_held = 1'b0;
                    if (c == CH_SLASH) begin
                        match_blanked_byte(CH_SPACE);
                        match_blanked_byte(CH_SPACE);
                        scanner.mode = MODE_LINE;
                    end else if (c == CH_STAR) begin
                        // opener star may also close: "/*/" is a full comment
                        match_blanked_byte(CH_SPACE);
                        match_blanked_byte(CH_SPACE);
                        scanner.mode = MODE_BLOCK_STAR;
                    end else begin
                        match_blanked_byte(CH_SLASH);
                        match_blanked_byte(c);
                    end
                end else if (c == CH_SLASH) begin
                    scanner.slash_held = 1'b1;
                end else begin
                    match_blanked_byte(c);
                end
            end
            MODE_LINE: begin
                if (c == CH_NL) begin
                    match_blanked_byte(CH_NL);
                    scanner.mode = MODE_NORMAL;
                end else begin
                    match_blanked_byte(CH_SPACE);
                end
            end
            MODE_BLOCK: begin
                match_blanked_byte(c == CH_NL ? CH_NL : CH_SPACE);
                if (c == CH_STAR)
                    scanner.mode = MODE_BLOCK_STAR;
            end
            default: begin
                if (c == CH_SLASH) begin
                    match_blanked_byte(CH_SPACE);
                    scanner.mode = MODE_NORMAL;
                end else if (c == CH_STAR) begin
                    match_blanked_byte(CH_SPACE);
                end else begin
                    match_blanked_byte(c == CH_NL ? CH_NL : CH_SPACE);
                    scanner.mode = MODE_BLOCK;
                end
            end
        endcase
    endfunction

    // One accepted source byte; returns 1 with the flags when the text closes.
    function automatic logic take_source_byte(logic [7:0] c, logic last,
                                              output logic [NAME_COUNT-1:0] flags);
        strip_source_byte(c);
        flags = '0;
        if (!last)
            return 1'b0;
        // a trailing slash outside any comment is plain text
        if (scanner.slash_held) begin
            scanner.slash_held = 1'b0;
            match_blanked_byte(CH_SLASH);
        end
        flags = scanner.found;
        clear_scanner();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: change at negedge, accept on the rising edge.
    // ------------------------------------------------------------------
    task automatic send_request(logic [7:0] ch, logic last, logic known,
                                logic [NAME_COUNT-1:0] known_flags);
        int                    idle;
        logic [NAME_COUNT-1:0] flags;
        idle = no_idle ? 0 : idle_cycles();
        repeat (idle) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid     <= 1'b1;
        in_if.text_byte <= ch;
        in_if.is_last   <= last;
        do @(posedge i_clk); while (!in_if.ready);
        accepted_bytes++;
        if (take_source_byte(ch, last, flags))
            pending_reports.push_back(known ? known_flags : flags);
    endtask

    // Hold off the sender until every owed report is out.
    task automatic wait_reports_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    function automatic void add_row(logic [7:0] ch, logic last, logic known,
                                    logic [NAME_COUNT-1:0] flags);
        t_text_row row;
        row.ch    = ch;
        row.last  = last;
        row.known = known;
        row.flags = flags;
        directed_rows.push_back(row);
    endfunction

    // Whole text, is_last on its final byte.
    function automatic void add_text(string s, logic known, logic [NAME_COUNT-1:0] flags);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], i == s.len() - 1, known, flags);
    endfunction

    // ------------------------------------------------------------------
    // Random text builder
    // ------------------------------------------------------------------
    function automatic void push_string(string s);
        for (int i = 0; i < s.len(); i++)
            text_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] random_word_byte();
        return word_pool[$urandom_range(0, word_pool.len() - 1)];
    endfunction

    function automatic logic [7:0] random_blank();
        return BLANK_BYTES[$urandom_range(0, 5)];
    endfunction

    function automatic void push_fragment();
        int    kind;
        int    n;
        string nm;
        kind = $urandom_range(0, 99);
        nm   = entry_name[$urandom_range(0, NAME_COUNT - 1)];
        if (kind < 22) begin
            // definition: name, optional blanks, '('
            push_string(nm);
            repeat ($urandom_range(0, 2)) text_bytes.push_back(random_blank());
            text_bytes.push_back(CH_LPAREN);
        end else if (kind < 34) begin
            push_string(nm);
        end else if (kind < 44) begin
            // near misses: truncated, extended on either side, one byte off
            case ($urandom_range(0, 3))
                0: push_string(nm.substr(0, nm.len() - 2));
                1: begin
                    push_string(nm);
                    text_bytes.push_back(random_word_byte());
                end
                2: begin
                    text_bytes.push_back(random_word_byte());
                    push_string(nm);
                end
                default: begin
                    n = $urandom_range(0, nm.len() - 1);
                    nm[n] = random_word_byte();
                    push_string(nm);
                end
            endcase
        end else if (kind < 56) begin
            repeat ($urandom_range(1, 3)) text_bytes.push_back(random_blank());
        end else if (kind < 62) begin
            text_bytes.push_back(CH_LPAREN);
        end else if (kind < 70) begin
            // plain words, some past the 15-byte saturation point
            repeat ($urandom_range(1, 20)) text_bytes.push_back(random_word_byte());
        end else if (kind < 77) begin
            push_string("//");
            repeat ($urandom_range(0, 6)) text_bytes.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) != 0)
                text_bytes.push_back(CH_NL);
        end else if (kind < 85) begin
            if ($urandom_range(0, 3) == 0) begin
                push_string("/*/");
            end else begin
                push_string("/*");
                repeat ($urandom_range(0, 6)) begin
                    case ($urandom_range(0, 3))
                        0: text_bytes.push_back(CH_STAR);
                        1: text_bytes.push_back(CH_NL);
                        2: text_bytes.push_back(CH_SLASH);
                        default: text_bytes.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                // sometimes left open, to run into the end of the text
                if ($urandom_range(0, 4) != 0)
                    push_string("*/");
            end
        end else if (kind < 93) begin
            text_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            text_bytes.push_back(punct_pool[$urandom_range(0, punct_pool.len() - 1)]);
        end
    endfunction

    function automatic void build_random_text();
        text_bytes.delete();
        if ($urandom_range(0, 99) < 12) begin
            // very short texts back up a second report behind a stalled one
            repeat ($urandom_range(1, 2)) text_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 8)) push_fragment();
        end
    endfunction

    // ------------------------------------------------------------------
    // Report receiver: random ready, compare on the rising edge.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
                stall = no_idle ? 0 : idle_cycles();
            end
        end
    end

    always @(posedge i_clk) begin
        logic [NAME_COUNT-1:0] got;
        logic [NAME_COUNT-1:0] want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.has_compute, out_if.has_domain, out_if.has_hull,
                   out_if.has_skinned_pixel, out_if.has_skinned_vertex,
                   out_if.has_pixel, out_if.has_vertex};
            if (pending_reports.size() == 0) begin
                flag_error($sformatf("report with nothing owed, flags %b", got));
            end else begin
                want = pending_reports.pop_front();
                for (int i = 0; i < NAME_COUNT; i++) begin
                    if (got[i] !== want[i])
                        flag_error($sformatf("%s got %b want %b",
                                             field_name[i], got[i], want[i]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int random_start;
        int text_count;
        error_count     = 0;
        accepted_bytes  = 0;
        no_idle         = 1'b0;
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.text_byte = 8'h00;
        in_if.is_last   = 1'b0;
        out_if.ready    = 1'b0;
        clear_scanner();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes as one-byte texts, trailing slash, a hit,
        // a name with no '(' at the end, "/*/" closing itself, line comment.
        add_row(8'h00, 1'b1, 1'b1, FOUND_NONE);
        add_row(8'hFF, 1'b1, 1'b1, FOUND_NONE);
        add_text("/", 1'b1, FOUND_NONE);
        add_text("CSMain(", 1'b1, FOUND_COMPUTE);
        add_text("/*/x", 1'b0, FOUND_NONE);
        add_text("//\n", 1'b0, FOUND_NONE);
        add_text("HSMain", 1'b1, FOUND_NONE);
        foreach (directed_rows[i])
            send_request(directed_rows[i].ch, directed_rows[i].last,
                         directed_rows[i].known, directed_rows[i].flags);
        wait_reports_drained();

        // Random texts; every ninth one waits for the report queue to empty,
        // and about one in six runs with no idling on either side.
        random_start = accepted_bytes;
        text_count   = 0;
        while (accepted_bytes - random_start < RANDOM_BYTES) begin
            text_count++;
            if (text_count % 9 == 0)
                wait_reports_drained();
            no_idle = ($urandom_range(0, 5) == 0);
            build_random_text();
            foreach (text_bytes[i])
                send_request(text_bytes[i], i == text_bytes.size() - 1, 1'b0, FOUND_NONE);
        end
        no_idle = 1'b0;

        wait_reports_drained();
        // spare edges afterwards catch stray reports
        repeat (8) @(posedge i_clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: comment_strip_entry_point_scanner.f
+incdir+sv
sv/cssc_pkg.sv
sv/cssc_ifs.sv
sv/comment_strip_entry_point_scanner.sv
bench/tb_comment_strip_entry_point_scanner.sv
